/* sv/tick_and_jittered_stat_scheduler_defines.svh */
// ----------------------------------------------------------------------------
// Tick scheduler assertion macros
// Shared concurrent assertion shorthands, clocked on clk_i, off in reset.
// ----------------------------------------------------------------------------
`ifndef TICK_AND_JITTERED_STAT_SCHEDULER_DEFINES_SVH
`define TICK_AND_JITTERED_STAT_SCHEDULER_DEFINES_SVH

// Condition that must hold at every clock edge
`define TJSS_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Consequence that must hold in the cycle after the trigger
`define TJSS_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

/* sv/tjss_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tick scheduler package
// Field widths, register codes, shared datapath types and the LFSR step.
// ----------------------------------------------------------------------------
package tjss_pkg;

  localparam int unsigned NOW_W      = 64;
  localparam int unsigned PERIOD_W   = 31;
  localparam int unsigned MIN_W      = 31;
  localparam int unsigned MASK_W     = 30;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned RELOAD_W   = 32;
  localparam int unsigned LFSR_W     = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 31;

  localparam logic [LFSR_W-1:0] LFSR_TAPS = 32'h8020_0003;
  localparam logic [LFSR_W-1:0] LFSR_SEED = 32'h0000_ACE1;
  localparam logic [CNT_W-1:0]  CNT_MAX   = 16'hFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TICK_PERIOD = 2'd0,
    CFG_STAT_MIN    = 2'd1,
    CFG_JITTER_MASK = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_IRQ   = 1'b1
  } kind_e;

  typedef struct packed {
    logic [NOW_W-1:0] a;
    logic [NOW_W-1:0] b;
    logic             sub;
  } alu_req_t;

  typedef struct packed {
    logic [NOW_W-1:0] sum;
    logic             carry;  // on subtract: a >= b
  } alu_res_t;

  typedef struct packed {
    logic                start;
    logic [NOW_W-1:0]    dividend;
    logic [PERIOD_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [NOW_W-1:0]    quot;
    logic [PERIOD_W-1:0] rem;
  } div_res_t;

  // Galois LFSR, shifting right
  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] s);
    logic [LFSR_W-1:0] n;
    n = {1'b0, s[LFSR_W-1:1]};
    if (s[0]) begin
      n = n ^ LFSR_TAPS;
    end
    return n;
  endfunction

endpackage

/* sv/tjss_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tick scheduler request channel
// Valid/ready channel carrying one start or interrupt request.
// ----------------------------------------------------------------------------
interface tjss_in_if import tjss_pkg::*; ();

  logic             valid;
  logic             ready;
  logic             kind;
  logic [NOW_W-1:0] timebase_now;
  logic             masked;

  modport source (output valid, kind, timebase_now, masked, input ready);
  modport sink   (input valid, kind, timebase_now, masked, output ready);

endinterface

/* sv/tjss_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tick scheduler result channel
// Valid/ready channel carrying the reload value and tick counts.
// ----------------------------------------------------------------------------
interface tjss_out_if import tjss_pkg::*; ();

  logic                valid;
  logic                ready;
  logic                ignored;
  logic [RELOAD_W-1:0] reload_value;
  logic [CNT_W-1:0]    hard_ticks;
  logic [CNT_W-1:0]    stat_ticks;

  modport source (output valid, ignored, reload_value, hard_ticks, stat_ticks, input ready);
  modport sink   (input valid, ignored, reload_value, hard_ticks, stat_ticks, output ready);

endinterface

/* sv/tjss_alu.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tick scheduler shared adder
// 64-bit add/subtract with carry out, used for every wide add and compare.
// ----------------------------------------------------------------------------
module tjss_alu import tjss_pkg::*; (
  input  alu_req_t req_i,
  output alu_res_t res_o
);

  logic [NOW_W:0] full;

  assign full = {1'b0, req_i.a} + {1'b0, req_i.b ^ {NOW_W{req_i.sub}}}
              + {{NOW_W{1'b0}}, req_i.sub};

  assign res_o.sum   = full[NOW_W-1:0];
  assign res_o.carry = full[NOW_W];

endmodule

/* sv/tjss_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tick scheduler divider
// Restoring 64 by 31 bit divider, one quotient bit a cycle, with an early
// exit when the dividend is already below the divisor.
// ----------------------------------------------------------------------------
module tjss_div import tjss_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_res_t res_o
);

  localparam int unsigned StepW = $clog2(NOW_W);
  localparam logic [StepW-1:0] LastStep = StepW'(NOW_W - 1);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic                chk_q, chk_d;
  logic [StepW-1:0]    cnt_q, cnt_d;
  logic [NOW_W-1:0]    quot_q, quot_d;
  logic [PERIOD_W-1:0] rem_q, rem_d;
  logic [PERIOD_W-1:0] divisor_q, divisor_d;

  logic [PERIOD_W:0]   shifted;
  logic [PERIOD_W+1:0] diff;
  logic                ge;
  logic                fits;

  assign shifted = {rem_q, quot_q[NOW_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, divisor_q};
  assign ge      = ~diff[PERIOD_W+1];
  assign fits    = ~|quot_q[NOW_W-1:PERIOD_W] && (quot_q[PERIOD_W-1:0] < divisor_q);

  always_comb begin
    busy_d    = busy_q;
    done_d    = 1'b0;
    chk_d     = chk_q;
    cnt_d     = cnt_q;
    quot_d    = quot_q;
    rem_d     = rem_q;
    divisor_d = divisor_q;
    if (req_i.start) begin
      quot_d    = req_i.dividend;
      divisor_d = req_i.divisor;
      rem_d     = '0;
      cnt_d     = '0;
      busy_d    = 1'b1;
      chk_d     = 1'b1;
    end else if (busy_q) begin
      if (chk_q) begin
        chk_d = 1'b0;
        if (fits) begin
          rem_d  = quot_q[PERIOD_W-1:0];
          quot_d = '0;
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      end else begin
        rem_d  = ge ? diff[PERIOD_W-1:0] : shifted[PERIOD_W-1:0];
        quot_d = {quot_q[NOW_W-2:0], ge};
        cnt_d  = cnt_q + StepW'(1);
        if (cnt_q == LastStep) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      chk_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      chk_q  <= chk_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q    <= quot_d;
    rem_q     <= rem_d;
    divisor_q <= divisor_d;
  end

  assign res_o.busy = busy_q;
  assign res_o.done = done_q;
  assign res_o.quot = quot_q;
  assign res_o.rem  = rem_q;

endmodule

/* sv/tick_and_jittered_stat_scheduler.sv */
`timescale 1ns / 1ps
// Flow: a start request sets both deadlines from now; an interrupt with zero tick period is
// ignored; other interrupts catch the tick and stat deadlines up over the shared adder and
// divider, with an LFSR redraw per stat tick, and unless masked count the hard ticks since
// the last one with a further division.
// Throughput: one request at a time; the next is taken while the result waits at the output.
// Reset: state, config, deadlines and LFSR reset at once, no sweep; data registers do not.
// ----------------------------------------------------------------------------
// Periodic tick and jittered statistics tick scheduler
// Sequencer over one shared 64-bit adder and one iterative divider.
// ----------------------------------------------------------------------------
`include "tick_and_jittered_stat_scheduler_defines.svh"

module tick_and_jittered_stat_scheduler import tjss_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  tjss_in_if.sink               req_i,
  tjss_out_if.source            rsp_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  typedef enum logic [16:0] {
    ST_IDLE  = 17'h00001,
    ST_START = 17'h00002,
    ST_TCMP  = 17'h00004,
    ST_TDIV  = 17'h00008,
    ST_TADV1 = 17'h00010,
    ST_TADV2 = 17'h00020,
    ST_TPREV = 17'h00040,
    ST_SCMP  = 17'h00080,
    ST_DRAW  = 17'h00100,
    ST_SADD  = 17'h00200,
    ST_NEAR  = 17'h00400,
    ST_RELD  = 17'h00800,
    ST_LCMP  = 17'h01000,
    ST_LDIV  = 17'h02000,
    ST_LADV1 = 17'h04000,
    ST_LADV2 = 17'h08000,
    ST_DONE  = 17'h10000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [PERIOD_W-1:0] tick_period_q;
  logic [MIN_W-1:0]    stat_min_q;
  logic [MASK_W-1:0]   jitter_mask_q;

  // scheduler state
  logic [NOW_W-1:0]  tick_dl_q, tick_dl_d;
  logic [NOW_W-1:0]  stat_dl_q, stat_dl_d;
  logic [NOW_W-1:0]  last_q, last_d;
  logic [CNT_W-1:0]  pending_q, pending_d;
  logic [LFSR_W-1:0] lfsr_q, lfsr_d;
  logic [CNT_W-1:0]  nstats_q, nstats_d;

  // per-request working registers
  logic [NOW_W-1:0]    now_q, now_d;
  logic                masked_q, masked_d;
  logic [NOW_W-1:0]    scratch_q, scratch_d;
  logic [NOW_W-1:0]    prev_q, prev_d;
  logic [NOW_W-1:0]    near_q, near_d;
  logic [MIN_W:0]      inc_q, inc_d;
  logic                res_ign_q, res_ign_d;
  logic [RELOAD_W-1:0] res_reload_q, res_reload_d;
  logic [CNT_W-1:0]    res_hard_q, res_hard_d;
  logic [CNT_W-1:0]    res_stats_q, res_stats_d;

  // output register
  logic                out_valid_q, out_valid_d;
  logic                out_ign_q;
  logic [RELOAD_W-1:0] out_reload_q;
  logic [CNT_W-1:0]    out_hard_q;
  logic [CNT_W-1:0]    out_stats_q;
  logic                out_load;

  alu_req_t alu_req;
  alu_res_t alu_res;
  div_req_t div_req;
  div_res_t div_res;

  logic                req_acc;
  logic [LFSR_W-1:0]   lfsr_next;
  logic [MASK_W-1:0]   jitter;
  logic [CNT_W:0]      stat_sum;
  logic [CNT_W-1:0]    stat_sat;
  logic [CNT_W:0]      hard_sum;
  logic                rem_nz;

  tjss_alu u_alu (
    .req_i (alu_req),
    .res_o (alu_res)
  );

  tjss_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .res_o  (div_res)
  );

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;

  assign lfsr_next = lfsr_step(lfsr_q);
  assign jitter    = lfsr_next[MASK_W-1:0] & jitter_mask_q;
  assign stat_sum  = {1'b0, pending_q} + {1'b0, nstats_q};
  assign stat_sat  = stat_sum[CNT_W] ? CNT_MAX : stat_sum[CNT_W-1:0];
  assign rem_nz    = |div_res.rem;
  assign hard_sum  = {1'b0, div_res.quot[CNT_W-1:0]} + {{CNT_W{1'b0}}, rem_nz};

  always_comb begin
    state_d      = state_q;
    tick_dl_d    = tick_dl_q;
    stat_dl_d    = stat_dl_q;
    last_d       = last_q;
    pending_d    = pending_q;
    lfsr_d       = lfsr_q;
    nstats_d     = nstats_q;
    now_d        = now_q;
    masked_d     = masked_q;
    scratch_d    = scratch_q;
    prev_d       = prev_q;
    near_d       = near_q;
    inc_d        = inc_q;
    res_ign_d    = res_ign_q;
    res_reload_d = res_reload_q;
    res_hard_d   = res_hard_q;
    res_stats_d  = res_stats_q;
    out_load     = 1'b0;
    alu_req      = '{a: '0, b: '0, sub: 1'b0};
    div_req      = '{start: 1'b0, dividend: alu_res.sum, divisor: tick_period_q};

    unique case (state_q)
      ST_IDLE: begin
        if (req_acc) begin
          now_d        = req_i.timebase_now;
          masked_d     = req_i.masked;
          nstats_d     = '0;
          res_ign_d    = 1'b0;
          res_reload_d = '0;
          res_hard_d   = '0;
          res_stats_d  = '0;
          if (req_i.kind == KIND_START) begin
            state_d = ST_START;
          end else if (tick_period_q == '0) begin
            res_ign_d = 1'b1;
            state_d   = ST_DONE;
          end else begin
            state_d = ST_TCMP;
          end
        end
      end
      ST_START: begin
        alu_req      = '{a: now_q, b: {33'b0, tick_period_q}, sub: 1'b0};
        tick_dl_d    = alu_res.sum;
        stat_dl_d    = alu_res.sum;
        last_d       = now_q;
        pending_d    = '0;
        res_reload_d = {1'b0, tick_period_q};
        state_d      = ST_DONE;
      end
      ST_TCMP: begin
        // tick deadline not after now: catch up by whole periods
        alu_req = '{a: now_q, b: tick_dl_q, sub: 1'b1};
        if (alu_res.carry) begin
          div_req.start = 1'b1;
          state_d       = ST_TDIV;
        end else begin
          state_d = ST_TPREV;
        end
      end
      ST_TDIV: begin
        if (div_res.done) begin
          state_d = ST_TADV1;
        end
      end
      ST_TADV1: begin
        alu_req   = '{a: now_q, b: {33'b0, div_res.rem}, sub: 1'b1};
        scratch_d = alu_res.sum;
        state_d   = ST_TADV2;
      end
      ST_TADV2: begin
        alu_req   = '{a: scratch_q, b: {33'b0, tick_period_q}, sub: 1'b0};
        tick_dl_d = alu_res.sum;
        state_d   = ST_TPREV;
      end
      ST_TPREV: begin
        alu_req = '{a: tick_dl_q, b: {33'b0, tick_period_q}, sub: 1'b1};
        prev_d  = alu_res.sum;
        state_d = ST_SCMP;
      end
      ST_SCMP: begin
        alu_req = '{a: now_q, b: stat_dl_q, sub: 1'b1};
        if (alu_res.carry && (nstats_q != CNT_MAX)) begin
          state_d = ST_DRAW;
        end else begin
          state_d = ST_NEAR;
        end
      end
      ST_DRAW: begin
        // redraw until the masked value is nonzero, single step if mask is zero
        lfsr_d = lfsr_next;
        if ((jitter != '0) || (jitter_mask_q == '0)) begin
          inc_d   = {1'b0, stat_min_q} + {2'b00, jitter};
          state_d = ST_SADD;
        end
      end
      ST_SADD: begin
        alu_req   = '{a: stat_dl_q, b: {32'b0, inc_q}, sub: 1'b0};
        stat_dl_d = alu_res.sum;
        nstats_d  = nstats_q + CNT_W'(1);
        state_d   = ST_SCMP;
      end
      ST_NEAR: begin
        alu_req = '{a: tick_dl_q, b: stat_dl_q, sub: 1'b1};
        near_d  = alu_res.carry ? stat_dl_q : tick_dl_q;
        state_d = ST_RELD;
      end
      ST_RELD: begin
        alu_req = '{a: near_q, b: now_q, sub: 1'b1};
        if (!alu_res.carry || (alu_res.sum == '0)) begin
          res_reload_d = '0;
        end else if (|alu_res.sum[NOW_W-1:RELOAD_W]) begin
          res_reload_d = '1;
        end else begin
          res_reload_d = alu_res.sum[RELOAD_W-1:0];
        end
        if (masked_q) begin
          pending_d = stat_sat;
          state_d   = ST_DONE;
        end else begin
          res_stats_d = stat_sat;
          pending_d   = '0;
          state_d     = ST_LCMP;
        end
      end
      ST_LCMP: begin
        // last tick time below previous deadline: count periods elapsed
        alu_req = '{a: prev_q, b: last_q, sub: 1'b1};
        if (alu_res.carry && (alu_res.sum != '0)) begin
          div_req.start = 1'b1;
          state_d       = ST_LDIV;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_LDIV: begin
        if (div_res.done) begin
          if ((|div_res.quot[NOW_W-1:CNT_W]) || hard_sum[CNT_W]) begin
            res_hard_d = CNT_MAX;
          end else begin
            res_hard_d = hard_sum[CNT_W-1:0];
          end
          if (rem_nz) begin
            state_d = ST_LADV1;
          end else begin
            last_d  = prev_q;
            state_d = ST_DONE;
          end
        end
      end
      ST_LADV1: begin
        alu_req   = '{a: prev_q, b: {33'b0, div_res.rem}, sub: 1'b1};
        scratch_d = alu_res.sum;
        state_d   = ST_LADV2;
      end
      ST_LADV2: begin
        alu_req = '{a: scratch_q, b: {33'b0, tick_period_q}, sub: 1'b0};
        last_d  = alu_res.sum;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      tick_period_q <= '0;
      stat_min_q    <= MIN_W'(1);
      jitter_mask_q <= MASK_W'(1);
      tick_dl_q     <= '0;
      stat_dl_q     <= '0;
      last_q        <= '0;
      pending_q     <= '0;
      lfsr_q        <= LFSR_SEED;
      nstats_q      <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      tick_dl_q   <= tick_dl_d;
      stat_dl_q   <= stat_dl_d;
      last_q      <= last_d;
      pending_q   <= pending_d;
      lfsr_q      <= lfsr_d;
      nstats_q    <= nstats_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_TICK_PERIOD: tick_period_q <= cfg_data_i[PERIOD_W-1:0];
          CFG_STAT_MIN:    stat_min_q    <= cfg_data_i[MIN_W-1:0];
          CFG_JITTER_MASK: jitter_mask_q <= cfg_data_i[MASK_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    now_q        <= now_d;
    masked_q     <= masked_d;
    scratch_q    <= scratch_d;
    prev_q       <= prev_d;
    near_q       <= near_d;
    inc_q        <= inc_d;
    res_ign_q    <= res_ign_d;
    res_reload_q <= res_reload_d;
    res_hard_q   <= res_hard_d;
    res_stats_q  <= res_stats_d;
    if (out_load) begin
      out_ign_q    <= res_ign_q;
      out_reload_q <= res_reload_q;
      out_hard_q   <= res_hard_q;
      out_stats_q  <= res_stats_q;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.ignored      = out_ign_q;
  assign rsp_o.reload_value = out_reload_q;
  assign rsp_o.hard_ticks   = out_hard_q;
  assign rsp_o.stat_ticks   = out_stats_q;

  `TJSS_ASSERT_NEXT(a_busy_after_req, req_acc, !req_i.ready, "request taken while busy")
  `TJSS_ASSERT(a_div_start_idle, !(div_req.start && div_res.busy), "divider restarted mid-run")
  `TJSS_ASSERT(a_ignored_zero, !(out_valid_q && out_ign_q) || ((out_reload_q == '0) && (out_hard_q == '0) && (out_stats_q == '0)), "ignored result not zero")

endmodule
